@@ sv/b64sd_pkg.sv @@
// Package for the base64 stream decoder: constants, types and the sextet lookup.
package b64sd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_BITS       = 16;
  localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 16'hffff;

  localparam logic [7:0] BAD_SEXTET = 8'hff;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] SEXTET_PLUS  = 8'h3e;
  localparam logic [7:0] SEXTET_SLASH = 8'h3f;
  localparam logic [7:0] DIGIT_BASE   = 8'h34;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // what one accepted item causes
  typedef struct packed {
    logic emit_data;   // a decoded byte is produced
    logic emit_stat;   // a status follows (item marked last)
    logic data_end;    // run_end for the data byte
    logic stat_error;  // error flag for the status
  } step_flags_t;

  // 6-bit value of a base64 character, BAD_SEXTET outside the alphabet
  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = BAD_SEXTET;
    if (c inside {[8'h41:8'h5a]}) v = c - 8'h41;
    else if (c inside {[8'h61:8'h7a]}) v = c - 8'h61 + 8'd26;
    else if (c inside {[8'h30:8'h39]}) v = c - 8'h30 + DIGIT_BASE;
    else if (c == CHAR_PLUS) v = SEXTET_PLUS;
    else if (c == CHAR_SLASH) v = SEXTET_SLASH;
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  endfunction

endpackage

@@ sv/base64_stream_decoder.sv @@
// Top level of the base64 stream decoder: state, capacity register and result buffer.
//
// Usage notes
// - Input channel in_valid/in_ready carries one text character per item,
//   with last marking the final character of a string.
// - Output channel out_valid/out_ready carries result items: kind 0 is a
//   decoded byte in data_byte, kind 1 is the end-of-string status with
//   byte_count (0 on error) and error. run_end marks the final result of
//   an input item.
// - capacity is written through cfg_wr_en/cfg_wr_data while idle; it resets
//   to 65535 and limits the bytes per string before overflow is flagged.
// - A result is registered and appears in the cycle after its item is accepted.
// - Throughput: one item per cycle while out_ready is high and each item
//   gives at most one result; an item marked last that also emits a byte
//   gives two results and holds the input while the data result drains.
// - The decode is one pass of lookup and shifts between the input
//   handshake and the two-slot result buffer (data slot, status slot).
// - A new item is taken while the single pending result is being taken.
// - Receiver stall: results stay in the buffer, in_ready drops, nothing is
//   lost.
// - Reset (rst, synchronous): string state cleared, buffer empty, capacity
//   back to 65535.
module base64_stream_decoder #(
  parameter int COUNT_BITS = b64sd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [b64sd_pkg::CAP_BITS-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     text_char,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [7:0]                     data_byte,
  output logic [b64sd_pkg::CAP_BITS-1:0] byte_count,
  output logic                           error,
  output logic                           run_end
);
  import b64sd_pkg::*;

  // string state
  logic [CAP_BITS-1:0]   capacity;
  logic [5:0]            held;
  logic [1:0]            pos;
  logic [COUNT_BITS-1:0] count;
  logic                  stopped;
  logic                  err;

  logic [5:0]            held_next;
  logic [1:0]            pos_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  stopped_next;
  logic                  err_next;
  logic [7:0]            byte_next;
  logic [CAP_BITS-1:0]   stat_count_next;
  step_flags_t           flags;

  // result buffer
  logic                  dat_pend;
  logic                  stat_pend;
  logic [7:0]            dat_byte;
  logic                  dat_end;
  logic [CAP_BITS-1:0]   stat_count;
  logic                  stat_err;

  logic accept;
  logic pop;

  b64sd_step #(.COUNT_BITS(COUNT_BITS)) u_step (
    .text_char    (text_char),
    .last         (last),
    .capacity     (capacity),
    .held         (held),
    .pos          (pos),
    .count        (count),
    .stopped      (stopped),
    .err          (err),
    .held_next    (held_next),
    .pos_next     (pos_next),
    .count_next   (count_next),
    .stopped_next (stopped_next),
    .err_next     (err_next),
    .byte_out     (byte_next),
    .stat_count   (stat_count_next),
    .flags        (flags)
  );

  // room for the next item once the buffer is empty or its only result goes
  assign in_ready  = (!dat_pend && !stat_pend) || (out_ready && (dat_pend ^ stat_pend));
  assign accept    = in_valid && in_ready;
  assign out_valid = dat_pend || stat_pend;
  assign pop       = out_valid && out_ready;

  // data slot drains before the status slot
  assign kind       = dat_pend ? KIND_DATA : KIND_STATUS;
  assign data_byte  = dat_pend ? dat_byte : 8'h00;
  assign byte_count = dat_pend ? '0 : stat_count;
  assign error      = dat_pend ? 1'b0 : stat_err;
  assign run_end    = dat_pend ? dat_end : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAPACITY_RESET;
      held      <= 6'd0;
      pos       <= 2'd0;
      count     <= '0;
      stopped   <= 1'b0;
      err       <= 1'b0;
      dat_pend  <= 1'b0;
      stat_pend <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (accept) begin
        held      <= held_next;
        pos       <= pos_next;
        count     <= count_next;
        stopped   <= stopped_next;
        err       <= err_next;
        dat_pend  <= flags.emit_data;
        stat_pend <= flags.emit_stat;
      end else if (pop) begin
        if (dat_pend) begin
          dat_pend <= 1'b0;
        end else begin
          stat_pend <= 1'b0;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      dat_byte   <= byte_next;
      dat_end    <= flags.data_end;
      stat_count <= stat_count_next;
      stat_err   <= flags.stat_error;
    end
  end

endmodule

@@ sv/b64sd_step.sv @@
// Combinational decode of one character: next state, data byte and result flags.
module b64sd_step #(
  parameter int COUNT_BITS = b64sd_pkg::COUNT_BITS_DEF
) (
  input  logic [7:0]                    text_char,
  input  logic                          last,
  input  logic [b64sd_pkg::CAP_BITS-1:0] capacity,
  input  logic [5:0]                    held,
  input  logic [1:0]                    pos,
  input  logic [COUNT_BITS-1:0]         count,
  input  logic                          stopped,
  input  logic                          err,
  output logic [5:0]                    held_next,
  output logic [1:0]                    pos_next,
  output logic [COUNT_BITS-1:0]         count_next,
  output logic                          stopped_next,
  output logic                          err_next,
  output logic [7:0]                    byte_out,
  output logic [b64sd_pkg::CAP_BITS-1:0] stat_count,
  output b64sd_pkg::step_flags_t        flags
);
  import b64sd_pkg::*;

  localparam int CW = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

  logic [7:0]            v;
  logic                  full;
  logic                  emit;
  logic [5:0]            h;
  logic [1:0]            p;
  logic [COUNT_BITS-1:0] n;
  logic                  s;
  logic                  e;
  logic [CW-1:0]         n_wide;

  assign v    = sextet_of(text_char);
  assign full = (CW'(count) >= CW'(capacity)) || (&count);

  always_comb begin
    h    = held;
    p    = pos;
    n    = count;
    s    = stopped;
    e    = err;
    emit = 1'b0;
    byte_out = 8'h00;
    if (!stopped && !is_blank(text_char)) begin
      if (text_char == CHAR_NUL || text_char == CHAR_PAD) begin
        s = 1'b1;
      end else if (v == BAD_SEXTET) begin
        e = 1'b1;
        s = 1'b1;
      end else if (pos == 2'd0) begin
        h = v[5:0];
        p = 2'd1;
      end else if (full) begin
        e = 1'b1;
        s = 1'b1;
      end else begin
        emit = 1'b1;
        case (pos)
          2'd1:    byte_out = {held, v[5:4]};
          2'd2:    byte_out = {held[3:0], v[5:2]};
          default: byte_out = {held[1:0], v[5:0]};
        endcase
        n = count + COUNT_BITS'(1);
        h = v[5:0];
        p = pos + 2'd1;
      end
    end
  end

  assign n_wide     = CW'(n);
  assign stat_count = e ? '0 : n_wide[CAP_BITS-1:0];

  assign flags.emit_data  = emit;
  assign flags.emit_stat  = last;
  assign flags.data_end   = !last;
  assign flags.stat_error = e;

  // item marked last returns the string state to reset
  assign held_next    = last ? 6'd0 : h;
  assign pos_next     = last ? 2'd0 : p;
  assign count_next   = last ? '0 : n;
  assign stopped_next = last ? 1'b0 : s;
  assign err_next     = last ? 1'b0 : e;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for base64_stream_decoder: random text strings against a decode predictor.
module tb;
  import b64sd_pkg::*;

  // Character codes the predictor and the stimulus both care about
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PAD   = 8'h3d;

  localparam logic [CAP_BITS-1:0] CAP_AT_RESET = 16'hffff;
  localparam int QUIET_LIMIT = 4000;   // cycles with no handshake on either side
  localparam int HOLD_AFTER  = 300;    // items taken before the long output hold-off
  localparam int HOLD_CYCLES = 150;

  // One text character on its way in
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_item_t;

  // One result as the block should present it
  typedef struct packed {
    logic                kind;
    logic [7:0]          data;
    logic [CAP_BITS-1:0] count;
    logic                err;
    logic                fin;
  } result_t;

  logic                clk;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic [CAP_BITS-1:0] cfg_wr_data = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [7:0]          text_char   = 8'h00;
  logic                last        = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic                kind;
  logic [7:0]          data_byte;
  logic [CAP_BITS-1:0] byte_count;
  logic                error;
  logic                run_end;

  base64_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_char   (text_char),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .byte_count  (byte_count),
    .error       (error),
    .run_end     (run_end)
  );

  // Stimulus and expectation stores
  text_item_t chars_to_send[$];
  result_t    results_due[$];
  int         queued      = 0;   // items pushed by the stimulus
  int         chars_taken = 0;   // items accepted by the block
  int         results_seen = 0;
  int         mismatches  = 0;

  // Predictor state: mirrors one string in flight plus the capacity register
  logic [CAP_BITS-1:0] cap_reg = CAP_AT_RESET;
  logic [5:0]          held_bits;
  logic [1:0]          slot;
  logic [15:0]         bytes_out;
  logic                halted;
  logic                bad_seen;

  // Idle/stall control for each side
  int  send_gap   = 0;
  bit  send_calm  = 1'b0;
  int  ready_wait = 0;
  bit  take_calm  = 1'b0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  int  quiet      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one; none at all while calm
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // bit 6 set: not a base64 alphabet character
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h40;
    if (c >= 8'h41 && c <= 8'h5a)      v = c - 8'h41;          // A-Z
    else if (c >= 8'h61 && c <= 8'h7a) v = c - 8'h61 + 8'd26;  // a-z
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;  // 0-9
    else if (c == CH_PLUS)             v = 8'd62;
    else if (c == CH_SLASH)            v = 8'd63;
    return v[6:0];
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
    if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
    return (v == 6'd62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic clear_string();
    held_bits = '0;
    slot      = '0;
    bytes_out = '0;
    halted    = 1'b0;
    bad_seen  = 1'b0;
  endtask

  // Predictor: one accepted character in, zero to two results queued
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [6:0] sx;
    result_t    r;
    if (!halted && !is_blank(c)) begin
      sx = sextet_value(c);
      if (c == CH_NUL || c == CH_PAD) begin
        halted = 1'b1;                       // end mark, no error
      end else if (sx[6]) begin
        bad_seen = 1'b1;
        halted   = 1'b1;
      end else if (slot == 2'd0) begin
        held_bits = sx[5:0];
        slot      = 2'd1;
      end else if (bytes_out >= cap_reg || bytes_out == 16'hffff) begin
        bad_seen = 1'b1;                     // overflow: byte dropped
        halted   = 1'b1;
      end else begin
        r      = '0;
        r.kind = KIND_DATA;
        case (slot)
          2'd1:    r.data = {held_bits, sx[5:4]};
          2'd2:    r.data = {held_bits[3:0], sx[5:2]};
          default: r.data = {held_bits[1:0], sx[5:0]};
        endcase
        r.fin = !fin;
        results_due.push_back(r);
        bytes_out = bytes_out + 16'd1;
        held_bits = sx[5:0];
        slot      = slot + 2'd1;
      end
    end
    if (fin) begin
      r       = '0;
      r.kind  = KIND_STATUS;
      r.count = bad_seen ? '0 : bytes_out;
      r.err   = bad_seen;
      r.fin   = 1'b1;
      results_due.push_back(r);
      clear_string();
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    $display("mismatch on %s at result %0d: expected %h, got %h",
             what, results_seen, want, got);
    mismatches++;
  endtask

  task automatic push_char(input logic [7:0] c, input logic fin);
    text_item_t t;
    t.ch  = c;
    t.fin = fin;
    chars_to_send.push_back(t);
    queued++;
  endtask

  // One random string: mostly well-formed text, some spoilt, some pure noise
  task automatic queue_string();
    logic [7:0] txt[$];
    int style;
    int groups;
    int tail;
    int n;
    int pos;
    style = $urandom_range(0, 19);
    if (style < 3) begin
      n = $urandom_range(1, 6);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      groups = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      tail   = $urandom_range(0, 3);
      if (style >= 6 && tail == 1) tail = 0;   // well-formed text never leaves a lone char
      for (n = 0; n < groups * 4 + tail; n++) begin
        if ($urandom_range(0, 7) == 0) txt.push_back(blank_char());
        txt.push_back(alphabet_char(6'($urandom_range(0, 63))));
      end
      if (tail != 0 && $urandom_range(0, 1) == 1)
        repeat (4 - tail) txt.push_back(CH_PAD);
      if ($urandom_range(0, 5) == 0) txt.push_back(blank_char());
      // rubbish after the end; ignored if a pad came first
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
      if (style < 6 && txt.size() != 0) begin
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0:       txt[pos] = CH_NUL;
          1:       txt[pos] = CH_PAD;
          default: txt[pos] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    if (txt.size() == 0) begin
      case ($urandom_range(0, 2))
        0:       txt.push_back(blank_char());
        1:       txt.push_back(CH_PAD);
        default: txt.push_back(alphabet_char(6'($urandom_range(0, 63))));
      endcase
    end
    foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
  endtask

  // Nothing left to send, nothing in flight, nothing owed
  task automatic wait_idle();
    do @(negedge clk);
    while (chars_to_send.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  // Quiesce, set capacity, then queue a batch of random strings
  task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int budget);
    int start;
    wait_idle();
    repeat (3) @(negedge clk);   // let an item with no result settle
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    cap_reg      = cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
    start = queued;
    while (queued - start < budget) queue_string();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: holds an item until taken, then a random gap before the next
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_text
    text_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // waiting on the block; payload stays put
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (chars_to_send.size() != 0) begin
      nxt       = chars_to_send.pop_front();
      in_valid  <= 1'b1;
      text_char <= nxt.ch;
      last      <= nxt.fin;
      send_gap  <= idle_len(send_calm);
      if ($urandom_range(0, 63) == 0) send_calm <= !send_calm;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output back-pressure: random stalls, plus one long hold-off mid-run so the
  // result buffer fills and in_ready has to drop
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pace_results
    int gap;
    if (rst) begin
      out_ready  <= 1'b0;
      ready_wait <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (!hold_done && chars_taken >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      out_ready  <= 1'b0;
    end else begin
      gap        = idle_len(take_calm);
      out_ready  <= (gap == 0);
      ready_wait <= (gap == 0) ? 0 : gap - 1;
      if ($urandom_range(0, 63) == 0) take_calm <= !take_calm;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check a taken result against the oldest one owed, then predict
  // from a taken item. A result never comes out on its item's own edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    result_t want;
    if (rst) begin
      clear_string();
      cap_reg = CAP_AT_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch("result with nothing owed", 16'd0, {8'd0, data_byte});
        end else begin
          want = results_due.pop_front();
          if (kind !== want.kind)
            flag_mismatch("kind", 16'(want.kind), 16'(kind));
          if (data_byte !== want.data)
            flag_mismatch("data_byte", 16'(want.data), 16'(data_byte));
          if (byte_count !== want.count)
            flag_mismatch("byte_count", want.count, byte_count);
          if (error !== want.err)
            flag_mismatch("error", 16'(want.err), 16'(error));
          if (run_end !== want.fin)
            flag_mismatch("run_end", 16'(want.fin), 16'(run_end));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        decode_char(text_char, last);
        chars_taken <= chars_taken + 1;
      end
    end
  end

  // Watchdog: too long with nothing moving on either side
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAIL base64_stream_decoder");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed strings at the reset capacity, then random
  // batches under several capacities, each started from an idle block
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // space, tab and line feed between valid chars; last one emits a byte and a status
    push_char(CH_SLASH, 1'b0);
    push_char(CH_SPACE, 1'b0);
    push_char(CH_PLUS,  1'b0);
    push_char(CH_TAB,   1'b0);
    push_char(8'h39,    1'b0);   // '9'
    push_char(CH_LF,    1'b0);
    push_char(8'h7a,    1'b1);   // 'z'
    // pad stops decoding; later chars, even bad ones, are ignored
    push_char(8'h41,    1'b0);   // 'A'
    push_char(8'h42,    1'b0);   // 'B'
    push_char(CH_PAD,   1'b0);
    push_char(8'h51,    1'b0);   // 'Q'
    push_char(8'hff,    1'b0);
    push_char(CH_FF,    1'b1);
    // char outside the alphabet flags an error and stops
    push_char(8'h54,    1'b0);   // 'T'
    push_char(8'h2a,    1'b0);   // '*'
    push_char(8'h78,    1'b1);   // 'x'
    // NUL ends the string early; a partial group keeps only bytes already out
    push_char(8'h67,    1'b0);   // 'g'
    push_char(8'h6f,    1'b0);   // 'o'
    push_char(CH_NUL,   1'b0);
    push_char(CH_VT,    1'b0);
    push_char(8'h80,    1'b1);
    // a string of one bad char, and a short one ended with a carriage return
    push_char(8'h7f,    1'b1);
    push_char(8'h30,    1'b0);   // '0'
    push_char(CH_CR,    1'b1);

    // capacities: none, tiny, random small, full range, random wide
    run_phase(16'd0,    118);
    run_phase(16'd1,    118);
    run_phase(16'd2,    118);
    run_phase(16'($urandom_range(0, 20)), 118);
    run_phase(16'hffff, 118);
    run_phase(16'($urandom_range(0, 65535)), 118);
    run_phase(16'd5,    117);

    wait_idle();
    repeat (8) @(negedge clk);   // catch any stray late result
    if (mismatches == 0) begin
      $display("PASS base64_stream_decoder");
    end else begin
      $display("FAIL base64_stream_decoder");
    end
    $finish;
  end

endmodule
